FILE: hdl/voxel_grid_trilinear_sampler_macros.svh
// ----------------------------------------------------------------------------
// Voxel grid sampler assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef VOXEL_GRID_TRILINEAR_SAMPLER_MACROS_SVH
`define VOXEL_GRID_TRILINEAR_SAMPLER_MACROS_SVH

// same-cycle implication
`define VGTS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vgts: same-cycle check failed");

// next-cycle implication
`define VGTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vgts: next-cycle check failed");

`endif

FILE: hdl/vgts_pkg.sv
// ----------------------------------------------------------------------------
// Voxel grid sampler package
// Types, field widths and codes shared by the sampler modules.
// ----------------------------------------------------------------------------
package vgts_pkg;

  localparam int SIZE_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W     = 15;
  localparam int VAL_W     = 16;
  localparam int COORD_W   = 18;
  localparam int OUT_W     = 16;
  localparam int FRAC_W    = 16;
  localparam int SPLIT_W   = 26;                 // c*n - 0.5 in Q.16
  localparam int FLOOR_W   = SPLIT_W - FRAC_W;   // signed floor
  localparam int ROW_W     = 2 * SIZE_W + 1;     // z*Y + y
  localparam int ADDR_W    = 19;                 // (z*Y + y)*X + x
  localparam int CORNER_PAD = 8;                 // extra fraction bits per corner

  localparam logic [SIZE_W-1:0] GRID_RESET = SIZE_W'(32);
  localparam logic [FRAC_W:0]   HALF       = (FRAC_W + 1)'(32768);
  localparam logic [OUT_W-1:0]  OUT_MAX    = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 2'd2;

  // item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [2:0] LAST_CORNER = 3'd7;
  localparam logic [2:0] LAST_XLERP  = 3'd3;
  localparam logic [2:0] LAST_YLERP  = 3'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_WAIT_C,
    S_XL,
    S_WAIT_X,
    S_YL,
    S_WAIT_Y,
    S_ZL,
    S_WAIT_Z
  } state_t;

  typedef enum logic [1:0] {
    LVL_X,
    LVL_Y,
    LVL_Z
  } lvl_t;

  typedef struct packed {
    logic       accept;
    logic       issue;
    logic [2:0] corner;
    logic       issue_last;
    logic       lerp_go;
    lvl_t       lerp_lvl;
    logic       lerp_last;
  } dp_cmd_t;

  typedef struct packed {
    logic corners_in;   // last corner landed in the corner line
    logic lerp_last;    // last lerp of the current level landed
  } dp_stat_t;

endpackage

FILE: hdl/voxel_grid_trilinear_sampler.sv
// ----------------------------------------------------------------------------
// Voxel grid trilinear sampler
// Voxel density store with a trilinear sample path and size registers.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  ------    ---------------------  ----------------------------------------
//  item in   start & !busy          kind, voxel_index, voxel_value, coord_*
//  result    done (one cycle)       sampled_density
//  config    cfg_we                 cfg_index, cfg_data
//
//  A write item is written into voxel memory at accept; busy stays low.
//  A sample item keeps busy high from accept to done, through the eight
//  corner reads on the single voxel memory port and the lerp pipe.
//  The next item is taken in the cycle done is shown.
//  Reset clears control and sets the grid sizes to 32; voxel memory holds
//  whatever it held. The result receiver cannot stall.
// ----------------------------------------------------------------------------
module voxel_grid_trilinear_sampler import vgts_pkg::*; #(
  parameter int MAX_VOXELS   = 32768,
  parameter int DENSITY_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind,
  input  logic [IDX_W-1:0]          voxel_index,
  input  logic [VAL_W-1:0]          voxel_value,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  output logic                      done,
  output logic [OUT_W-1:0]          sampled_density,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [SIZE_W-1:0]         cfg_data
);

  logic [SIZE_W-1:0] grid_size_x, grid_size_y, grid_size_z;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size_x <= GRID_RESET;
      grid_size_y <= GRID_RESET;
      grid_size_z <= GRID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_X: grid_size_x <= cfg_data;
        REG_GRID_Y: grid_size_y <= cfg_data;
        REG_GRID_Z: grid_size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  vgts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  vgts_dp #(
    .MAX_VOXELS   (MAX_VOXELS),
    .DENSITY_BITS (DENSITY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .kind            (kind),
    .voxel_index     (voxel_index),
    .voxel_value     (voxel_value),
    .coord_x         (coord_x),
    .coord_y         (coord_y),
    .coord_z         (coord_z),
    .grid_size_x     (grid_size_x),
    .grid_size_y     (grid_size_y),
    .grid_size_z     (grid_size_z),
    .done            (done),
    .sampled_density (sampled_density)
  );

endmodule

FILE: hdl/vgts_ctrl.sv
// ----------------------------------------------------------------------------
// Voxel grid sampler controller
// Sequences corner fetch and the three lerp levels of one sample item.
// ----------------------------------------------------------------------------
module vgts_ctrl import vgts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     kind,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_cmd_t  cmd
);

  state_t     state, state_next;
  logic [2:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start && kind == KIND_SAMPLE) state_next = S_FETCH;
      S_FETCH:  if (cnt == LAST_CORNER) state_next = S_WAIT_C;
      S_WAIT_C: if (stat.corners_in) state_next = S_XL;
      S_XL:     if (cnt == LAST_XLERP) state_next = S_WAIT_X;
      S_WAIT_X: if (stat.lerp_last) state_next = S_YL;
      S_YL:     if (cnt == LAST_YLERP) state_next = S_WAIT_Y;
      S_WAIT_Y: if (stat.lerp_last) state_next = S_ZL;
      S_ZL:     state_next = S_WAIT_Z;
      S_WAIT_Z: if (stat.lerp_last) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // counter runs inside the issuing states, cleared on every change
  always_comb begin
    if ((state == S_FETCH || state == S_XL || state == S_YL) && state_next == state) begin
      cnt_next = cnt + 3'd1;
    end else begin
      cnt_next = '0;
    end
  end

  always_comb begin
    busy           = (state != S_IDLE);
    cmd            = '0;
    cmd.corner     = cnt;
    cmd.lerp_lvl   = LVL_X;
    unique case (state)
      S_IDLE: begin
        cmd.accept = start;
      end
      S_FETCH: begin
        cmd.issue      = 1'b1;
        cmd.issue_last = (cnt == LAST_CORNER);
      end
      S_XL: begin
        cmd.lerp_go   = 1'b1;
        cmd.lerp_lvl  = LVL_X;
        cmd.lerp_last = (cnt == LAST_XLERP);
      end
      S_YL: begin
        cmd.lerp_go   = 1'b1;
        cmd.lerp_lvl  = LVL_Y;
        cmd.lerp_last = (cnt == LAST_YLERP);
      end
      S_ZL: begin
        cmd.lerp_go   = 1'b1;
        cmd.lerp_lvl  = LVL_Z;
        cmd.lerp_last = 1'b1;
      end
      S_WAIT_C, S_WAIT_X, S_WAIT_Y, S_WAIT_Z: begin
        cmd.issue = 1'b0;
      end
      default: begin
        cmd.issue = 1'b0;
      end
    endcase
  end

endmodule

FILE: hdl/vgts_dp.sv
// ----------------------------------------------------------------------------
// Voxel grid sampler datapath
// Axis split, corner address pipe, voxel memory, lerp pipe and output reg.
// ----------------------------------------------------------------------------
module vgts_dp import vgts_pkg::*; #(
  parameter int MAX_VOXELS   = 32768,
  parameter int DENSITY_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  output dp_stat_t                  stat,
  input  logic                      kind,
  input  logic [IDX_W-1:0]          voxel_index,
  input  logic [VAL_W-1:0]          voxel_value,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic [SIZE_W-1:0]         grid_size_x,
  input  logic [SIZE_W-1:0]         grid_size_y,
  input  logic [SIZE_W-1:0]         grid_size_z,
  output logic                      done,
  output logic [OUT_W-1:0]          sampled_density
);

  localparam int AW = $clog2(MAX_VOXELS);
  localparam int DW = DENSITY_BITS;
  localparam int VW = DW + CORNER_PAD;
  localparam int PW = VW + FRAC_W + 2;

  function automatic logic signed [SPLIT_W-1:0] split_f(
    input logic signed [COORD_W-1:0] c,
    input logic [SIZE_W-1:0]         n
  );
    logic signed [SPLIT_W-1:0] ce;
    logic signed [SPLIT_W-1:0] ne;
    ce = SPLIT_W'(c);
    ne = $signed({{(SPLIT_W - SIZE_W){1'b0}}, n});
    return ce * ne - $signed(SPLIT_W'(HALF));
  endfunction

  function automatic logic axis_ok(
    input logic signed [FLOOR_W:0] c,
    input logic [SIZE_W-1:0]       n
  );
    return !c[FLOOR_W] && (c[FLOOR_W-1:0] < FLOOR_W'(n));
  endfunction

  // ---- axis split ----
  logic signed [SPLIT_W-1:0] fx, fy, fz;
  logic signed [FLOOR_W-1:0] ix, iy, iz;
  logic [FRAC_W-1:0]         tx, ty, tz;

  assign fx = split_f(coord_x, grid_size_x);
  assign fy = split_f(coord_y, grid_size_y);
  assign fz = split_f(coord_z, grid_size_z);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ix <= fx[SPLIT_W-1:FRAC_W];
      iy <= fy[SPLIT_W-1:FRAC_W];
      iz <= fz[SPLIT_W-1:FRAC_W];
      tx <= fx[FRAC_W-1:0];
      ty <= fy[FRAC_W-1:0];
      tz <= fz[FRAC_W-1:0];
    end
  end

  // ---- corner address pipe ----
  logic signed [FLOOR_W:0] cx, cy, cz;
  logic                    ok_a_next;
  logic [ROW_W-1:0]        row_a_next;

  assign cx = $signed({ix[FLOOR_W-1], ix}) + $signed({{FLOOR_W{1'b0}}, cmd.corner[0]});
  assign cy = $signed({iy[FLOOR_W-1], iy}) + $signed({{FLOOR_W{1'b0}}, cmd.corner[1]});
  assign cz = $signed({iz[FLOOR_W-1], iz}) + $signed({{FLOOR_W{1'b0}}, cmd.corner[2]});
  assign ok_a_next = axis_ok(cx, grid_size_x) && axis_ok(cy, grid_size_y)
                   && axis_ok(cz, grid_size_z);
  assign row_a_next = ROW_W'(cz[SIZE_W-1:0]) * ROW_W'(grid_size_y)
                    + ROW_W'(cy[SIZE_W-1:0]);

  logic              v_a, ok_a, last_a;
  logic [ROW_W-1:0]  row_a;
  logic [SIZE_W-1:0] cx_a;
  logic              v_b, ok_b, last_b;
  logic [ADDR_W-1:0] addr_b;
  logic [ADDR_W-1:0] addr_b_next;
  logic              v_c, ok_c, last_c;
  logic [DW-1:0]     rdata;

  assign addr_b_next = ADDR_W'(row_a) * ADDR_W'(grid_size_x) + ADDR_W'(cx_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
    end else begin
      v_a <= cmd.issue;
      v_b <= v_a;
      v_c <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    ok_a   <= ok_a_next;
    last_a <= cmd.issue_last;
    row_a  <= row_a_next;
    cx_a   <= cx[SIZE_W-1:0];
    ok_b   <= ok_a && (32'(addr_b_next) < 32'(MAX_VOXELS));
    last_b <= last_a;
    addr_b <= addr_b_next;
    ok_c   <= ok_b;
    last_c <= last_b;
  end

  // ---- voxel memory: writes only while idle, so one port serves both ----
  logic [DW-1:0] mem [MAX_VOXELS];
  logic          wr_en;

  assign wr_en = cmd.accept && kind == KIND_WRITE
              && (32'(voxel_index) < 32'(MAX_VOXELS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(voxel_index)] <= DW'(voxel_value);
    end else if (v_b) begin
      rdata <= mem[AW'(addr_b)];
    end
  end

  // ---- corner line, then x and y result lines ----
  logic [VW-1:0] cl [8];
  logic [VW-1:0] xq [4];
  logic [VW-1:0] yq [2];
  logic [VW-1:0] corner_val;

  assign corner_val = ok_c ? {rdata, {CORNER_PAD{1'b0}}} : '0;

  // ---- lerp pipe: a + (((b - a)*t + half) >>> 16) ----
  logic [VW-1:0]         op_a, op_b;
  logic [FRAC_W-1:0]     op_t;
  logic                  v1, v2, last1, last2;
  lvl_t                  lvl1, lvl2;
  logic [VW-1:0]         la1, la2;
  logic signed [VW:0]    ldiff;
  logic [FRAC_W-1:0]     lt;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  rnd;
  logic signed [PW-1:0]  sh;
  logic [VW-1:0]         res;
  logic [VW:0]           fin;
  logic [VW-CORNER_PAD:0] fin_top;
  logic [OUT_W-1:0]      sat;

  always_comb begin
    case (cmd.lerp_lvl)
      LVL_X: begin
        op_a = cl[0];
        op_b = cl[1];
        op_t = tx;
      end
      LVL_Y: begin
        op_a = xq[0];
        op_b = xq[1];
        op_t = ty;
      end
      LVL_Z: begin
        op_a = yq[0];
        op_b = yq[1];
        op_t = tz;
      end
      default: begin
        op_a = '0;
        op_b = '0;
        op_t = '0;
      end
    endcase
  end

  assign rnd = prod + $signed(PW'(HALF));
  assign sh  = rnd >>> FRAC_W;
  assign res = la2 + sh[VW-1:0];   // true result fits, wrap is exact

  // round off the padding bits and clamp
  assign fin     = (VW + 1)'(res) + (VW + 1)'(128);
  assign fin_top = fin[VW:CORNER_PAD];
  assign sat     = (64'(fin_top) > 64'(OUT_MAX)) ? OUT_MAX : OUT_W'(fin_top);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= cmd.lerp_go;
      v2   <= v1;
      done <= v2 && lvl2 == LVL_Z;
    end
  end

  always_ff @(posedge clk) begin
    la1   <= op_a;
    ldiff <= $signed({1'b0, op_b}) - $signed({1'b0, op_a});
    lt    <= op_t;
    lvl1  <= cmd.lerp_lvl;
    last1 <= cmd.lerp_last;
    la2   <= la1;
    prod  <= PW'(ldiff) * PW'($signed({1'b0, lt}));
    lvl2  <= lvl1;
    last2 <= last1;
  end

  always_ff @(posedge clk) begin
    if (v_c) begin
      for (int i = 0; i < 7; i++) cl[i] <= cl[i+1];
      cl[7] <= corner_val;
    end else if (cmd.lerp_go && cmd.lerp_lvl == LVL_X) begin
      for (int i = 0; i < 6; i++) cl[i] <= cl[i+2];
    end

    if (v2 && lvl2 == LVL_X) begin
      for (int i = 0; i < 3; i++) xq[i] <= xq[i+1];
      xq[3] <= res;
    end else if (cmd.lerp_go && cmd.lerp_lvl == LVL_Y) begin
      for (int i = 0; i < 2; i++) xq[i] <= xq[i+2];
    end

    if (v2 && lvl2 == LVL_Y) begin
      yq[0] <= yq[1];
      yq[1] <= res;
    end

    if (v2 && lvl2 == LVL_Z) begin
      sampled_density <= sat;
    end
  end

  assign stat.corners_in = v_c && last_c;
  assign stat.lerp_last  = v2 && last2;

endmodule

FILE: hdl/vgts_checker.sv
// ----------------------------------------------------------------------------
// Voxel grid sampler port checker
// Watches the item handshake and the result strobe at the top level ports.
// ----------------------------------------------------------------------------
`include "voxel_grid_trilinear_sampler_macros.svh"

module vgts_checker import vgts_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic kind,
  input logic done
);

  // a sample item occupies the block, a write item does not
  `VGTS_ASSERT_NEXT(a_sample_busy, clk, rst, start && !busy && kind == KIND_SAMPLE, busy)
  `VGTS_ASSERT_NEXT(a_write_free, clk, rst, start && !busy && kind == KIND_WRITE, !busy)
  // result is a single-cycle strobe
  `VGTS_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  // the block frees up exactly as its result shows
  `VGTS_ASSERT_IMPL(a_free_on_done, clk, rst, $fell(busy), done)

endmodule

bind voxel_grid_trilinear_sampler vgts_checker u_vgts_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .kind  (kind),
  .done  (done)
);
